// File: src/c8_pkg.sv
package c8_pkg;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_AW    = 12;
  localparam int unsigned FB_ROWS   = 32;
  localparam int unsigned FB_AW     = 5;
  localparam int unsigned FB_WIDTH  = 64;
  localparam int unsigned NUM_V     = 16;

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [3:0]  REG_VF   = 4'hF;

  localparam logic [2:0] KIND_EXEC = 3'd0;
  localparam logic [2:0] KIND_TICK = 3'd1;
  localparam logic [2:0] KIND_KEY  = 3'd2;
  localparam logic [2:0] KIND_LOAD = 3'd3;
  localparam logic [2:0] KIND_ROW  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADOP = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_UNF   = 2'd3;

  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SEQ   = 4'h3;
  localparam logic [3:0] OP_SNE   = 4'h4;
  localparam logic [3:0] OP_SREQ  = 4'h5;
  localparam logic [3:0] OP_LDV   = 4'h6;
  localparam logic [3:0] OP_ADDV  = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SRNE  = 4'h9;
  localparam logic [3:0] OP_LDI   = 4'hA;
  localparam logic [3:0] OP_JPV0  = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;
  localparam logic [3:0] OP_DRW   = 4'hD;
  localparam logic [3:0] OP_KEY   = 4'hE;
  localparam logic [3:0] OP_MISC  = 4'hF;

  localparam logic [7:0] SYS_CLS  = 8'hE0;
  localparam logic [7:0] SYS_RET  = 8'hEE;
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] F_GETDT  = 8'h07;
  localparam logic [7:0] F_SETDT  = 8'h15;
  localparam logic [7:0] F_SETST  = 8'h18;
  localparam logic [7:0] F_ADDI   = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STORE  = 8'h55;
  localparam logic [7:0] F_LOAD   = 8'h65;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef struct packed {
    logic       legal;
    logic       flag_we;
    logic       flag;
    logic [7:0] res;
  } alu_t;

  typedef enum logic [4:0] {
    S_IDLE, S_F0, S_F1, S_RX, S_RY, S_CAPY, S_DEC, S_WRX, S_RET,
    S_DRAW, S_DRAW2, S_BCD, S_ST0, S_ST1, S_LD0, S_LD1, S_ROW, S_DONE
  } state_e;

endpackage

// File: src/c8_req_if.sv
interface c8_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  key_index;
  logic        key_pressed;
  logic [11:0] load_address;
  logic [7:0]  load_data;
  logic [7:0]  random_byte;
  logic [4:0]  row_select;

  modport source (
    output valid, kind, key_index, key_pressed, load_address, load_data,
           random_byte, row_select,
    input  ready
  );
  modport sink (
    input  valid, kind, key_index, key_pressed, load_address, load_data,
           random_byte, row_select,
    output ready
  );
endinterface

// File: src/c8_rsp_if.sv
interface c8_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] program_counter;
  logic        beep;
  logic [63:0] display_row;
  logic [15:0] executed_opcode;

  modport source (
    output valid, status, program_counter, beep, display_row, executed_opcode,
    input  ready
  );
  modport sink (
    input  valid, status, program_counter, beep, display_row, executed_opcode,
    output ready
  );
endinterface

// File: src/c8_ram.sv
module c8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/c8_alu.sv
module c8_alu (
  input  logic [7:0]   vx_i,
  input  logic [7:0]   vy_i,
  input  logic [3:0]   fn_i,
  output c8_pkg::alu_t alu_o
);

  logic [8:0] sum;

  assign sum = {1'b0, vx_i} + {1'b0, vy_i};

  always_comb begin
    alu_o = '{legal: 1'b1, flag_we: 1'b0, flag: 1'b0, res: vy_i};
    case (fn_i)
      c8_pkg::ALU_MOV: alu_o.res = vy_i;
      c8_pkg::ALU_OR:  alu_o.res = vx_i | vy_i;
      c8_pkg::ALU_AND: alu_o.res = vx_i & vy_i;
      c8_pkg::ALU_XOR: alu_o.res = vx_i ^ vy_i;
      c8_pkg::ALU_ADD: begin
        alu_o.flag_we = 1'b1;
        alu_o.flag    = sum[8];
        alu_o.res     = sum[7:0];
      end
      c8_pkg::ALU_SUB: begin
        alu_o.flag_we = 1'b1;
        alu_o.flag    = vx_i > vy_i;
        alu_o.res     = vx_i - vy_i;
      end
      c8_pkg::ALU_SHR: begin
        alu_o.flag_we = 1'b1;
        alu_o.flag    = vx_i[0];
        alu_o.res     = {1'b0, vx_i[7:1]};
      end
      c8_pkg::ALU_SUBN: begin
        alu_o.flag_we = 1'b1;
        alu_o.flag    = vy_i > vx_i;
        alu_o.res     = vy_i - vx_i;
      end
      c8_pkg::ALU_SHL: begin
        alu_o.flag_we = 1'b1;
        alu_o.flag    = vx_i[7];
        alu_o.res     = {vx_i[6:0], 1'b0};
      end
      default: alu_o.legal = 1'b0;
    endcase
  end

endmodule

// File: src/chip8_instruction_core.sv
// Tick, key, load and unused kinds go to S_DONE; a row read passes S_ROW first.
// Execute fetches the opcode (S_F0, S_F1), reads Vx and Vy (S_RX, S_RY, S_CAPY) and
// decodes in S_DEC; flag-setting ALU ops add S_WRX, returns S_RET, BCD writes its three
// digits one per step, and sprite draws and block register moves go one row or register
// at a time through the memories. The core is idle once the result is registered.
// Reset is asynchronous; registers, frame buffer and keys read as zero after it.
module chip8_instruction_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  c8_req_if.sink   req_i,
  c8_rsp_if.source rsp_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  c8_pkg::state_e state_q, state_d;

  logic [2:0]    kind_q, kind_d;
  logic [7:0]    rnd_q, rnd_d;
  logic [11:0]   pc_q, pc_d;
  logic [15:0]   i_q, i_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [7:0]    dly_q, dly_d;
  logic [7:0]    snd_q, snd_d;
  logic [15:0]   keys_q, keys_d;
  logic [15:0]   vvalid_q, vvalid_d;
  logic [31:0]   fbvalid_q, fbvalid_d;
  logic          vrv_q, fbrv_q;
  logic [15:0]   op_q, op_d;
  logic [7:0]    vx_q, vx_d;
  logic [7:0]    vy_q, vy_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          coll_q, coll_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          res_beep_q, res_beep_d;
  logic [63:0]   res_row_q, res_row_d;
  logic          ov_q, ov_d;
  logic [1:0]    o_status_q, o_status_d;
  logic [11:0]   o_pc_q, o_pc_d;
  logic          o_beep_q, o_beep_d;
  logic [63:0]   o_row_q, o_row_d;
  logic [15:0]   o_op_q, o_op_d;

  logic          mem_we;
  logic [11:0]   mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          v_we;
  logic [3:0]    v_waddr, v_raddr;
  logic [7:0]    v_wdata, v_rdata;
  logic          fb_we;
  logic [4:0]    fb_waddr, fb_raddr;
  logic [63:0]   fb_wdata, fb_rdata;
  logic          stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [11:0]   stk_wdata, stk_rdata;

  logic [7:0]    vrd, rnd_val;
  logic [63:0]   fbd, spr;
  logic [127:0]  spr_wide;
  logic [11:0]   nxt, skp, iaddr;
  logic [3:0]    grp, xi, yi, ni;
  logic [7:0]    nn;
  logic [11:0]   bcd;
  c8_pkg::alu_t  alu;

  function automatic logic [11:0] to_bcd(input logic [7:0] a);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    if (a >= 8'd200) begin
      h = 2'd2;
      r = 7'(a - 8'd200);
    end else if (a >= 8'd100) begin
      h = 2'd1;
      r = 7'(a - 8'd100);
    end else begin
      h = 2'd0;
      r = a[6:0];
    end
    p = 15'({8'b0, r} * 15'd205);
    t = p[14:11];
    o = 7'(r - 7'({3'b0, t} * 7'd10));
    return {2'b0, h, t, o[3:0]};
  endfunction

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_BYTES)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::NUM_V)) u_vreg (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  c8_ram #(.WIDTH(c8_pkg::FB_WIDTH), .DEPTH(c8_pkg::FB_ROWS)) u_fb (
    .clk_i, .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );

  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  c8_alu u_alu (.vx_i(vx_q), .vy_i(vy_q), .fn_i(ni), .alu_o(alu));

  assign grp      = op_q[15:12];
  assign xi       = op_q[11:8];
  assign yi       = op_q[7:4];
  assign ni       = op_q[3:0];
  assign nn       = op_q[7:0];
  assign nxt      = pc_q + 12'd2;
  assign skp      = pc_q + 12'd4;
  assign iaddr    = i_q[11:0] + {8'b0, cnt_q};
  assign vrd      = vrv_q ? v_rdata : 8'h00;
  assign fbd      = fbrv_q ? fb_rdata : 64'h0;
  assign spr_wide = {mem_rdata, 56'b0, mem_rdata, 56'b0} >> vx_q[5:0];
  assign spr      = spr_wide[63:0];
  assign bcd      = to_bcd(vx_q);
  assign rnd_val  = rnd_q & nn;

  assign req_i.ready           = (state_q == c8_pkg::S_IDLE);
  assign rsp_o.valid           = ov_q;
  assign rsp_o.status          = o_status_q;
  assign rsp_o.program_counter = o_pc_q;
  assign rsp_o.beep            = o_beep_q;
  assign rsp_o.display_row     = o_row_q;
  assign rsp_o.executed_opcode = o_op_q;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    rnd_d        = rnd_q;
    pc_d         = pc_q;
    i_d          = i_q;
    sp_d         = sp_q;
    dly_d        = dly_q;
    snd_d        = snd_q;
    keys_d       = keys_q;
    vvalid_d     = vvalid_q;
    fbvalid_d    = fbvalid_q;
    op_d         = op_q;
    vx_d         = vx_q;
    vy_d         = vy_q;
    cnt_d        = cnt_q;
    coll_d       = coll_q;
    res_status_d = res_status_q;
    res_beep_d   = res_beep_q;
    res_row_d    = res_row_q;
    ov_d         = ov_q && !rsp_o.ready;
    o_status_d   = o_status_q;
    o_pc_d       = o_pc_q;
    o_beep_d     = o_beep_q;
    o_row_d      = o_row_q;
    o_op_d       = o_op_q;
    mem_we       = 1'b0;
    mem_waddr    = iaddr;
    mem_wdata    = vrd;
    mem_raddr    = iaddr;
    v_we         = 1'b0;
    v_waddr      = xi;
    v_wdata      = alu.res;
    v_raddr      = xi;
    fb_we        = 1'b0;
    fb_waddr     = 5'(vy_q[4:0] + {1'b0, cnt_q});
    fb_wdata     = fbd ^ spr;
    fb_raddr     = 5'(vy_q[4:0] + {1'b0, cnt_q});
    stk_we       = 1'b0;
    stk_waddr    = sp_q[SAW-1:0];
    stk_wdata    = pc_q;
    stk_raddr    = SAW'(sp_q - SPW'(1));

    case (state_q)
      c8_pkg::S_IDLE: begin
        if (req_i.valid) begin
          kind_d       = req_i.kind;
          rnd_d        = req_i.random_byte;
          op_d         = 16'h0;
          res_status_d = c8_pkg::ST_OK;
          res_beep_d   = 1'b0;
          res_row_d    = 64'h0;
          state_d      = c8_pkg::S_DONE;
          case (req_i.kind)
            c8_pkg::KIND_EXEC: begin
              mem_raddr = pc_q;
              state_d   = c8_pkg::S_F0;
            end
            c8_pkg::KIND_TICK: begin
              if (dly_q != 8'd0) begin
                dly_d = dly_q - 8'd1;
              end
              if (snd_q != 8'd0) begin
                snd_d      = snd_q - 8'd1;
                res_beep_d = (snd_q == 8'd2);
              end
            end
            c8_pkg::KIND_KEY: begin
              keys_d[req_i.key_index] = req_i.key_pressed;
            end
            c8_pkg::KIND_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = req_i.load_address;
              mem_wdata = req_i.load_data;
            end
            c8_pkg::KIND_ROW: begin
              fb_raddr = req_i.row_select;
              state_d  = c8_pkg::S_ROW;
            end
            default: ;
          endcase
        end
      end
      c8_pkg::S_ROW: begin
        res_row_d = fbd;
        state_d   = c8_pkg::S_DONE;
      end
      c8_pkg::S_F0: begin
        op_d[15:8] = mem_rdata;
        mem_raddr  = nxt - 12'd1;
        state_d    = c8_pkg::S_F1;
      end
      c8_pkg::S_F1: begin
        op_d[7:0] = mem_rdata;
        state_d   = c8_pkg::S_RX;
      end
      c8_pkg::S_RX: begin
        v_raddr = xi;
        state_d = c8_pkg::S_RY;
      end
      c8_pkg::S_RY: begin
        vx_d    = vrd;
        v_raddr = (grp == c8_pkg::OP_JPV0) ? 4'h0 : yi;
        state_d = c8_pkg::S_CAPY;
      end
      c8_pkg::S_CAPY: begin
        vy_d    = vrd;
        state_d = c8_pkg::S_DEC;
      end
      c8_pkg::S_DEC: begin
        state_d = c8_pkg::S_DONE;
        case (grp)
          c8_pkg::OP_SYS: begin
            if (nn == c8_pkg::SYS_CLS) begin
              fbvalid_d = '0;
              pc_d      = nxt;
            end else if (nn == c8_pkg::SYS_RET) begin
              if (sp_q == '0) begin
                res_status_d = c8_pkg::ST_UNF;
              end else begin
                sp_d    = sp_q - SPW'(1);
                state_d = c8_pkg::S_RET;
              end
            end else begin
              res_status_d = c8_pkg::ST_BADOP;
            end
          end
          c8_pkg::OP_JP: pc_d = op_q[11:0];
          c8_pkg::OP_CALL: begin
            if (sp_q == SPW'(STACK_DEPTH)) begin
              res_status_d = c8_pkg::ST_OVF;
            end else begin
              stk_we = 1'b1;
              sp_d   = sp_q + SPW'(1);
              pc_d   = op_q[11:0];
            end
          end
          c8_pkg::OP_SEQ:  pc_d = (vx_q == nn) ? skp : nxt;
          c8_pkg::OP_SNE:  pc_d = (vx_q != nn) ? skp : nxt;
          c8_pkg::OP_SREQ: pc_d = (vx_q == vy_q) ? skp : nxt;
          c8_pkg::OP_SRNE: pc_d = (vx_q != vy_q) ? skp : nxt;
          c8_pkg::OP_LDV: begin
            v_we    = 1'b1;
            v_wdata = nn;
            pc_d    = nxt;
          end
          c8_pkg::OP_ADDV: begin
            v_we    = 1'b1;
            v_wdata = vx_q + nn;
            pc_d    = nxt;
          end
          c8_pkg::OP_ALU: begin
            if (!alu.legal) begin
              res_status_d = c8_pkg::ST_BADOP;
            end else if (alu.flag_we) begin
              v_we    = 1'b1;
              v_waddr = c8_pkg::REG_VF;
              v_wdata = {7'b0, alu.flag};
              state_d = c8_pkg::S_WRX;
            end else begin
              v_we = 1'b1;
              pc_d = nxt;
            end
          end
          c8_pkg::OP_LDI: begin
            i_d  = {4'b0, op_q[11:0]};
            pc_d = nxt;
          end
          c8_pkg::OP_JPV0: pc_d = op_q[11:0] + {4'b0, vy_q};
          c8_pkg::OP_RND: begin
            v_we    = 1'b1;
            v_wdata = rnd_val;
            pc_d    = nxt;
          end
          c8_pkg::OP_DRW: begin
            cnt_d   = 4'd0;
            coll_d  = 1'b0;
            state_d = c8_pkg::S_DRAW;
          end
          c8_pkg::OP_KEY: begin
            if (nn == c8_pkg::KEY_SKP) begin
              pc_d = keys_q[vx_q[3:0]] ? skp : nxt;
            end else if (nn == c8_pkg::KEY_SKNP) begin
              pc_d = keys_q[vx_q[3:0]] ? nxt : skp;
            end else begin
              res_status_d = c8_pkg::ST_BADOP;
            end
          end
          default: begin
            pc_d = nxt;
            case (nn)
              c8_pkg::F_GETDT: begin
                v_we    = 1'b1;
                v_wdata = dly_q;
              end
              c8_pkg::F_SETDT: dly_d = vx_q;
              c8_pkg::F_SETST: snd_d = vx_q;
              c8_pkg::F_ADDI:  i_d = i_q + {8'b0, vx_q};
              c8_pkg::F_FONT:  i_d = {6'b0, vx_q, 2'b0} + {8'b0, vx_q};
              c8_pkg::F_BCD: begin
                pc_d    = pc_q;
                cnt_d   = 4'd0;
                state_d = c8_pkg::S_BCD;
              end
              c8_pkg::F_STORE: begin
                pc_d    = pc_q;
                cnt_d   = 4'd0;
                state_d = c8_pkg::S_ST0;
              end
              c8_pkg::F_LOAD: begin
                pc_d    = pc_q;
                cnt_d   = 4'd0;
                state_d = c8_pkg::S_LD0;
              end
              default: begin
                pc_d         = pc_q;
                res_status_d = c8_pkg::ST_BADOP;
              end
            endcase
          end
        endcase
      end
      c8_pkg::S_WRX: begin
        v_we = 1'b1;
        // A shift of VF itself shifts the flag that was just written.
        if (xi == c8_pkg::REG_VF && ni == c8_pkg::ALU_SHR) begin
          v_wdata = 8'h00;
        end else if (xi == c8_pkg::REG_VF && ni == c8_pkg::ALU_SHL) begin
          v_wdata = {6'b0, alu.flag, 1'b0};
        end
        pc_d    = nxt;
        state_d = c8_pkg::S_DONE;
      end
      c8_pkg::S_RET: begin
        pc_d    = stk_rdata + 12'd2;
        state_d = c8_pkg::S_DONE;
      end
      c8_pkg::S_DRAW: begin
        if (cnt_q == ni) begin
          v_we    = 1'b1;
          v_waddr = c8_pkg::REG_VF;
          v_wdata = {7'b0, coll_q};
          pc_d    = nxt;
          state_d = c8_pkg::S_DONE;
        end else begin
          state_d = c8_pkg::S_DRAW2;
        end
      end
      c8_pkg::S_DRAW2: begin
        fb_we              = 1'b1;
        fbvalid_d[fb_waddr] = 1'b1;
        coll_d             = coll_q | (|(fbd & spr));
        cnt_d              = cnt_q + 4'd1;
        state_d            = c8_pkg::S_DRAW;
      end
      c8_pkg::S_BCD: begin
        mem_we = 1'b1;
        case (cnt_q)
          4'd0:    mem_wdata = {4'b0, bcd[11:8]};
          4'd1:    mem_wdata = {4'b0, bcd[7:4]};
          default: mem_wdata = {4'b0, bcd[3:0]};
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) begin
          pc_d    = nxt;
          state_d = c8_pkg::S_DONE;
        end
      end
      c8_pkg::S_ST0: begin
        v_raddr = cnt_q;
        state_d = c8_pkg::S_ST1;
      end
      c8_pkg::S_ST1: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == xi) begin
          pc_d    = nxt;
          state_d = c8_pkg::S_DONE;
        end else begin
          state_d = c8_pkg::S_ST0;
        end
      end
      c8_pkg::S_LD0: begin
        state_d = c8_pkg::S_LD1;
      end
      c8_pkg::S_LD1: begin
        v_we    = 1'b1;
        v_waddr = cnt_q;
        v_wdata = mem_rdata;
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == xi) begin
          pc_d    = nxt;
          state_d = c8_pkg::S_DONE;
        end else begin
          state_d = c8_pkg::S_LD0;
        end
      end
      c8_pkg::S_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d       = 1'b1;
          o_status_d = res_status_q;
          o_pc_d     = pc_q;
          o_beep_d   = res_beep_q;
          o_row_d    = res_row_q;
          o_op_d     = op_q;
          state_d    = c8_pkg::S_IDLE;
        end
      end
      default: state_d = c8_pkg::S_IDLE;
    endcase

    if (v_we) begin
      vvalid_d[v_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= c8_pkg::S_IDLE;
      kind_q       <= c8_pkg::KIND_EXEC;
      rnd_q        <= 8'h0;
      pc_q         <= c8_pkg::PC_RESET;
      i_q          <= 16'h0;
      sp_q         <= '0;
      dly_q        <= 8'h0;
      snd_q        <= 8'h0;
      keys_q       <= 16'h0;
      vvalid_q     <= 16'h0;
      fbvalid_q    <= 32'h0;
      vrv_q        <= 1'b0;
      fbrv_q       <= 1'b0;
      op_q         <= 16'h0;
      vx_q         <= 8'h0;
      vy_q         <= 8'h0;
      cnt_q        <= 4'h0;
      coll_q       <= 1'b0;
      res_status_q <= c8_pkg::ST_OK;
      res_beep_q   <= 1'b0;
      res_row_q    <= 64'h0;
      ov_q         <= 1'b0;
      o_status_q   <= c8_pkg::ST_OK;
      o_pc_q       <= 12'h0;
      o_beep_q     <= 1'b0;
      o_row_q      <= 64'h0;
      o_op_q       <= 16'h0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      rnd_q        <= rnd_d;
      pc_q         <= pc_d;
      i_q          <= i_d;
      sp_q         <= sp_d;
      dly_q        <= dly_d;
      snd_q        <= snd_d;
      keys_q       <= keys_d;
      vvalid_q     <= vvalid_d;
      fbvalid_q    <= fbvalid_d;
      vrv_q        <= vvalid_q[v_raddr];
      fbrv_q       <= fbvalid_q[fb_raddr];
      op_q         <= op_d;
      vx_q         <= vx_d;
      vy_q         <= vy_d;
      cnt_q        <= cnt_d;
      coll_q       <= coll_d;
      res_status_q <= res_status_d;
      res_beep_q   <= res_beep_d;
      res_row_q    <= res_row_d;
      ov_q         <= ov_d;
      o_status_q   <= o_status_d;
      o_pc_q       <= o_pc_d;
      o_beep_q     <= o_beep_d;
      o_row_q      <= o_row_d;
      o_op_q       <= o_op_d;
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack level beyond stack depth");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q != c8_pkg::S_IDLE)
    else $error("request accepted but core stayed idle");

  a_err_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == c8_pkg::S_DONE && res_status_q != c8_pkg::ST_OK
      |-> kind_q == c8_pkg::KIND_EXEC)
    else $error("error status on a non-execute request");
`endif

endmodule
